// ===== src/rv32im_subset_core_step_macros.svh =====
// Assertion macros used by the port-level checker file
`ifndef RV32IM_SUBSET_CORE_STEP_MACROS_SVH
`define RV32IM_SUBSET_CORE_STEP_MACROS_SVH
// Assert an implication on every clock edge outside reset
`define RVC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Assert an implication whose consequent is checked in the next cycle
`define RVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/rvc_pkg.sv =====
// Shared types, opcodes and constants of the RV32IM subset core
package rvc_pkg;
  localparam int MemBytes = 4096;
  localparam int MemAw = $clog2(MemBytes);

  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [31:0] UpperMask = 32'hFFFFF000;

  // request payload: one instruction word
  typedef struct packed {
    logic [31:0] instr_word;
  } core_req_t;

  // result payload of one executed instruction
  typedef struct packed {
    logic [31:0]        executed_pc;
    logic [31:0]        next_pc;
    logic               reg_written;
    logic [4:0]         dest_index;
    logic signed [31:0] dest_value;
    logic               unknown_op;
  } core_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MEM, ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic take_instr;
    logic read_regs;
    logic exec;
    logic div_start;
    logic div_step;
    logic mem_step;
    logic commit;
    logic out_take;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic needs_div;
    logic needs_mem;
    logic div_done;
    logic mem_done;
    logic out_busy;
  } stat_t;
endpackage

// ===== src/rvc_stream_if.sv =====
// Valid/ready channel carrying a generic payload
interface rvc_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/rvc_ctrl.sv =====
// Controller state machine sequencing each instruction
module rvc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  input  rvc_pkg::stat_t st,
  output rvc_pkg::ctrl_t cmd
);
  rvc_pkg::state_t state, state_next;

  // hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= rvc_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // advance the sequence and issue commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    cmd.out_take = out_ready;
    unique case (state)
      rvc_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) state_next = rvc_pkg::ST_IDLE;
      end
      rvc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_instr = 1'b1;
          state_next = rvc_pkg::ST_READ;
        end
      end
      rvc_pkg::ST_READ: begin
        cmd.read_regs = 1'b1;
        state_next = rvc_pkg::ST_EXEC;
      end
      rvc_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (st.needs_div) begin
          cmd.div_start = 1'b1;
          state_next = rvc_pkg::ST_DIV;
        end else if (st.needs_mem) state_next = rvc_pkg::ST_MEM;
        else state_next = rvc_pkg::ST_DONE;
      end
      rvc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = rvc_pkg::ST_DONE;
      end
      rvc_pkg::ST_MEM: begin
        cmd.mem_step = 1'b1;
        if (st.mem_done) state_next = rvc_pkg::ST_DONE;
      end
      rvc_pkg::ST_DONE: begin
        if (!st.out_busy || out_ready) begin
          cmd.commit = 1'b1;
          state_next = rvc_pkg::ST_IDLE;
        end
      end
      default: state_next = rvc_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== src/rvc_datapath.sv =====
// Register file, ALU, divider, byte memory and output register
module rvc_datapath (
  input  logic clk,
  input  logic rst,
  input  rvc_pkg::ctrl_t cmd,
  output rvc_pkg::stat_t st,
  input  logic [31:0] in_word,
  output logic out_valid,
  output logic [31:0] o_executed_pc,
  output logic [31:0] o_next_pc,
  output logic o_reg_written,
  output logic [4:0] o_dest_index,
  output logic signed [31:0] o_dest_value,
  output logic o_unknown_op
);
  logic [31:0] regs [32];
  logic [31:0] pc, instr, ra, rb;
  logic [7:0] mem [rvc_pkg::MemBytes];
  logic [rvc_pkg::MemAw-1:0] clr_addr;
  logic [31:0] res_val, res_next;
  logic res_wr, res_unk;
  logic [6:0] opc, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  logic [31:0] immi, imms, immb, immj;
  logic [31:0] alu_val, ex_next, shamt_src, addr;
  logic ex_wr, ex_unk, is_div, is_load, is_store, take;
  logic [31:0] prod;
  // divider
  logic [31:0] dq, dr, dd, dvs, da;
  logic [5:0] dcnt;
  logic dneg_q, dneg_r, dzero, dovf, drem;
  logic [32:0] dsub;
  // memory sequencer
  logic [31:0] maddr, mdata, ldval, maddr_rd;
  logic [1:0] mi, mlast;
  logic [2:0] mf3;
  logic mst;
  logic [7:0] rdbyte;

  assign opc = instr[6:0];
  assign rd = instr[11:7];
  assign f3 = instr[14:12];
  assign f7 = instr[31:25];
  assign immi = {{20{instr[31]}}, instr[31:20]};
  assign imms = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign prod = ra * rb;

  // decode and compute the combinational result
  always_comb begin
    alu_val = 32'd0;
    ex_next = pc + 32'd4;
    ex_wr = 1'b0;
    ex_unk = 1'b0;
    is_div = 1'b0;
    is_load = 1'b0;
    is_store = 1'b0;
    take = 1'b0;
    shamt_src = (opc == rvc_pkg::OpReg) ? rb : immi;
    addr = ra + ((opc == rvc_pkg::OpStore) ? imms : immi);
    unique case (opc)
      rvc_pkg::OpReg: begin
        ex_wr = 1'b1;
        if (f7 == 7'h00) begin
          case (f3)
            3'd0: alu_val = ra + rb;
            3'd1: alu_val = ra << rb[4:0];
            3'd2: alu_val = {31'd0, $signed(ra) < $signed(rb)};
            3'd4: alu_val = ra ^ rb;
            3'd5: alu_val = ra >> rb[4:0];
            3'd6: alu_val = ra | rb;
            3'd7: alu_val = ra & rb;
            default: ex_unk = 1'b1;
          endcase
        end else if (f7 == 7'h20) begin
          if (f3 == 3'd0) alu_val = ra - rb;
          else if (f3 == 3'd5) alu_val = 32'($signed(ra) >>> rb[4:0]);
          else ex_unk = 1'b1;
        end else if (f7 == 7'h01) begin
          if (f3 == 3'd0) alu_val = prod;
          else if (f3 == 3'd4 || f3 == 3'd6) is_div = 1'b1;
          else ex_unk = 1'b1;
        end else ex_unk = 1'b1;
      end
      rvc_pkg::OpImm: begin
        ex_wr = 1'b1;
        case (f3)
          3'd0: alu_val = ra + immi;
          3'd2: alu_val = {31'd0, $signed(ra) < $signed(immi)};
          3'd4: alu_val = ra ^ immi;
          3'd6: alu_val = ra | immi;
          3'd7: alu_val = ra & immi;
          3'd1: if (f7 == 7'h00) alu_val = ra << shamt_src[4:0]; else ex_unk = 1'b1;
          3'd5: begin
            if (f7 == 7'h00) alu_val = ra >> shamt_src[4:0];
            else if (f7 == 7'h20) alu_val = 32'($signed(ra) >>> shamt_src[4:0]);
            else ex_unk = 1'b1;
          end
          default: ex_unk = 1'b1;
        endcase
      end
      rvc_pkg::OpLoad: begin
        ex_wr = 1'b1;
        if (f3 <= 3'd2) is_load = 1'b1; else ex_unk = 1'b1;
      end
      rvc_pkg::OpStore: begin
        if (f3 <= 3'd2) is_store = 1'b1; else ex_unk = 1'b1;
      end
      rvc_pkg::OpBranch: begin
        case (f3)
          3'd0: take = (ra == rb);
          3'd1: take = (ra != rb);
          3'd4: take = $signed(ra) < $signed(rb);
          3'd5: take = !($signed(ra) < $signed(rb));
          default: ex_unk = 1'b1;
        endcase
        if (take) ex_next = pc + immb;
      end
      rvc_pkg::OpJal: begin
        ex_wr = 1'b1;
        alu_val = pc + 32'd4;
        ex_next = pc + immj;
      end
      rvc_pkg::OpJalr: begin
        if (f3 == 3'd0) begin
          ex_wr = 1'b1;
          alu_val = pc + 32'd4;
          ex_next = (ra + immi) & ~32'd1;
        end else ex_unk = 1'b1;
      end
      rvc_pkg::OpLui: begin
        ex_wr = 1'b1;
        alu_val = instr & rvc_pkg::UpperMask;
      end
      rvc_pkg::OpAuipc: begin
        ex_wr = 1'b1;
        alu_val = pc + (instr & rvc_pkg::UpperMask);
      end
      default: ex_unk = 1'b1;
    endcase
    if (ex_unk) begin
      ex_wr = 1'b0;
      is_div = 1'b0;
      is_load = 1'b0;
      is_store = 1'b0;
      ex_next = pc + 32'd4;
    end
    if (rd == 5'd0) ex_wr = 1'b0;
  end

  assign dsub = {dr[30:0], dd[31]} - {1'b0, dvs};
  assign mlast = (mf3[1]) ? 2'd3 : (mf3[0] ? 2'd1 : 2'd0);
  // address read at each edge, so the byte of maddr is ready during its step
  assign maddr_rd = cmd.exec ? addr : maddr + 32'd1;

  // status to the controller
  always_comb begin
    st.clear_done = (clr_addr == rvc_pkg::MemAw'(rvc_pkg::MemBytes - 1));
    st.needs_div = is_div;
    st.needs_mem = is_load || is_store;
    st.div_done = (dcnt == 6'd32);
    st.mem_done = (mi == mlast);
    st.out_busy = out_valid;
  end

  // clear memory after reset, one byte a cycle
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_step && !st.clear_done) clr_addr <= clr_addr + 1'b1;
  end

  // write memory: clearing pass or store bytes
  always_ff @(posedge clk) begin
    if (cmd.clear_step) mem[clr_addr] <= 8'd0;
    else if (cmd.mem_step && mst) mem[maddr[rvc_pkg::MemAw-1:0]] <= mdata[7:0];
  end

  // read memory one byte ahead of the access sequence
  always_ff @(posedge clk) begin
    rdbyte <= mem[maddr_rd[rvc_pkg::MemAw-1:0]];
  end

  // sequence the memory access one byte per cycle
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      maddr <= addr;
      mdata <= rb;
      mi <= 2'd0;
      mf3 <= f3;
      mst <= is_store;
      ldval <= 32'd0;
    end else if (cmd.mem_step) begin
      maddr <= maddr + 32'd1;
      mdata <= mdata >> 8;
      mi <= mi + 2'd1;
      ldval[8*mi +: 8] <= rdbyte;
    end
  end

  // iterate the divider one quotient bit per cycle on magnitudes
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      da <= ra;
      dd <= ra[31] ? -ra : ra;
      dvs <= rb[31] ? -rb : rb;
      dr <= 32'd0;
      dq <= 32'd0;
      dcnt <= 6'd0;
      dneg_q <= ra[31] ^ rb[31];
      dneg_r <= ra[31];
      dzero <= (rb == 32'd0);
      dovf <= (ra == 32'h80000000) && (rb == 32'hFFFFFFFF);
      drem <= f3[1];
    end else if (cmd.div_step && dcnt != 6'd32) begin
      dcnt <= dcnt + 6'd1;
      dd <= dd << 1;
      if (!dsub[32]) begin
        dr <= dsub[31:0];
        dq <= {dq[30:0], 1'b1};
      end else begin
        dr <= {dr[30:0], dd[31]};
        dq <= {dq[30:0], 1'b0};
      end
    end
  end

  // register file, pc and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        case (i) inside
          2, 11: regs[i] <= 32'h7FFFFFDC;
          3: regs[i] <= 32'h10000000;
          10: regs[i] <= 32'd1;
          default: regs[i] <= 32'd0;
        endcase
      end
      pc <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) out_valid <= 1'b1;
      else if (cmd.out_take && out_valid) out_valid <= 1'b0;
      if (cmd.take_instr) instr <= in_word;
      if (cmd.read_regs) begin
        ra <= regs[instr[19:15]];
        rb <= regs[instr[24:20]];
      end
      if (cmd.exec) begin
        res_val <= alu_val;
        res_next <= ex_next;
        res_wr <= ex_wr;
        res_unk <= ex_unk;
      end
      if (cmd.div_step && st.div_done) begin
        if (dzero) res_val <= drem ? da : 32'hFFFFFFFF;
        else if (dovf) res_val <= drem ? 32'd0 : da;
        else if (drem) res_val <= dneg_r ? -dr : dr;
        else res_val <= dneg_q ? -dq : dq;
      end
      if (cmd.mem_step && st.mem_done && !mst) begin
        case (mf3[1:0])
          2'd0: res_val <= {{24{rdbyte[7]}}, rdbyte};
          2'd1: res_val <= {{16{rdbyte[7]}}, rdbyte, ldval[7:0]};
          default: res_val <= {rdbyte, ldval[23:0]};
        endcase
      end
      if (cmd.commit) begin
        if (res_wr) regs[rd] <= res_val;
        pc <= res_next;
        o_executed_pc <= pc;
        o_next_pc <= res_next;
        o_reg_written <= res_wr;
        o_dest_index <= res_wr ? rd : 5'd0;
        o_dest_value <= res_wr ? res_val : 32'd0;
        o_unknown_op <= res_unk;
      end
    end
  end
endmodule

// ===== src/rv32im_subset_core_step.sv =====
// Loads/stores move one byte per cycle through the data memory port, and DIV/REM
// produce one quotient bit per cycle; other requests go from execute to commit.
// Throughput: one instruction at a time; the next request is taken after commit.
// The result register holds while the sink stalls; the next request is still taken.
// Reset: synchronous; registers load their constants, then a clearing pass zeroes
// every byte of the data memory before the first request is accepted.
module rv32im_subset_core_step (
  input logic clk,
  input logic rst,
  rvc_stream_if.sink in_ch,
  rvc_stream_if.source out_ch
);
  rvc_pkg::ctrl_t cmd;
  rvc_pkg::stat_t st;
  logic [31:0] o_executed_pc, o_next_pc;
  logic o_reg_written, o_unknown_op;
  logic [4:0] o_dest_index;
  logic signed [31:0] o_dest_value;

  rvc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .st(st), .cmd(cmd)
  );

  rvc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .in_word(in_ch.data.instr_word),
    .out_valid(out_ch.valid), .o_executed_pc(o_executed_pc), .o_next_pc(o_next_pc),
    .o_reg_written(o_reg_written), .o_dest_index(o_dest_index),
    .o_dest_value(o_dest_value), .o_unknown_op(o_unknown_op)
  );

  // drive the result payload
  assign out_ch.data.executed_pc = o_executed_pc;
  assign out_ch.data.next_pc = o_next_pc;
  assign out_ch.data.reg_written = o_reg_written;
  assign out_ch.data.dest_index = o_dest_index;
  assign out_ch.data.dest_value = o_dest_value;
  assign out_ch.data.unknown_op = o_unknown_op;
endmodule

// ===== src/rvc_checker.sv =====
// Port-level checker for the core, bound to the top level
`include "rv32im_subset_core_step_macros.svh"
module rvc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] executed_pc,
  input logic [31:0] next_pc,
  input logic reg_written,
  input logic [4:0] dest_index,
  input logic [31:0] dest_value,
  input logic unknown_op
);
  `RVC_ASSERT_IMP(a_unk_nowrite, clk, rst, out_valid && unknown_op,
    !reg_written && next_pc == executed_pc + 32'd4, "unknown op wrote or jumped")
  `RVC_ASSERT_IMP(a_x0, clk, rst, out_valid && reg_written, dest_index != 5'd0,
    "write to x0 reported")
  `RVC_ASSERT_IMP(a_nowr_zero, clk, rst, out_valid && !reg_written,
    dest_index == 5'd0 && dest_value == 32'd0, "idle write fields not zero")
  `RVC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(executed_pc), "stalled result changed")
  `RVC_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready,
    "second request taken while busy")
endmodule

bind rv32im_subset_core_step rvc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .executed_pc(out_ch.data.executed_pc), .next_pc(out_ch.data.next_pc),
  .reg_written(out_ch.data.reg_written), .dest_index(out_ch.data.dest_index),
  .dest_value(out_ch.data.dest_value), .unknown_op(out_ch.data.unknown_op)
);

// ===== tb/rv32im_subset_core_step_tb.sv =====
// Self-checking testbench for the RV32IM subset core: directed table, then random programs
module rv32im_subset_core_step_tb;

  typedef struct {
    logic [31:0]           word;
    bit                    typed;
    rvc_pkg::core_result_t want;
  } stim_row_t;

  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Alt = 7'h20;
  localparam logic [6:0] F7MulDiv = 7'h01;
  localparam logic [2:0] F3Add = 3'd0;
  localparam logic [2:0] F3Sll = 3'd1;
  localparam logic [2:0] F3Slt = 3'd2;
  localparam logic [2:0] F3Xor = 3'd4;
  localparam logic [2:0] F3Srl = 3'd5;
  localparam logic [2:0] F3Or = 3'd6;
  localparam logic [2:0] F3And = 3'd7;
  localparam logic [2:0] F3Mul = 3'd0;
  localparam logic [2:0] F3Div = 3'd4;
  localparam logic [2:0] F3Rem = 3'd6;
  localparam logic [2:0] F3Byte = 3'd0;
  localparam logic [2:0] F3Half = 3'd1;
  localparam logic [2:0] F3Word = 3'd2;
  localparam logic [2:0] F3Beq = 3'd0;
  localparam logic [2:0] F3Bne = 3'd1;
  localparam logic [2:0] F3Blt = 3'd4;
  localparam logic [2:0] F3Bge = 3'd5;
  localparam int RandomItems = 1130;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rvc_stream_if #(.payload_t(rvc_pkg::core_req_t)) in_ch ();
  rvc_stream_if #(.payload_t(rvc_pkg::core_result_t)) out_ch ();

  rv32im_subset_core_step DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow architectural state
  logic [31:0] shadow_regs [32];
  logic [31:0] shadow_pc;
  logic [7:0]  shadow_mem [rvc_pkg::MemBytes];

  rvc_pkg::core_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int  fail_count = 0;
  bit  calm = 1'b0;
  bit  hold_sink = 1'b0;
  int  idle_cycles = 0;

  function automatic logic [7:0] mem_byte_at(logic [31:0] addr);
    return shadow_mem[addr[rvc_pkg::MemAw-1:0]];
  endfunction

  function automatic logic [31:0] signed_div(logic [31:0] a, logic [31:0] b, bit want_rem);
    if (b == 32'd0) return want_rem ? a : 32'hFFFFFFFF;
    if (a == 32'h80000000 && b == 32'hFFFFFFFF) return want_rem ? 32'd0 : a;
    return want_rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
  endfunction

  // Execute one instruction on the shadow state and return its result
  function automatic rvc_pkg::core_result_t execute_instr(logic [31:0] w);
    logic [6:0] opc;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] a, b, immi, imm, nxt, val, pc, addr;
    logic [7:0] m0, m1, m2, m3;
    logic wr, unk, take;
    rvc_pkg::core_result_t r;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = shadow_regs[w[19:15]];
    b = shadow_regs[w[24:20]];
    immi = {{20{w[31]}}, w[31:20]};
    pc = shadow_pc;
    nxt = pc + 32'd4;
    val = '0;
    wr = 1'b0;
    unk = 1'b0;
    take = 1'b0;
    case (opc)
      rvc_pkg::OpReg: begin
        wr = 1'b1;
        if (f7 == F7Base) begin
          case (f3)
            F3Add: val = a + b;
            F3Sll: val = a << b[4:0];
            F3Slt: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3Xor: val = a ^ b;
            F3Srl: val = a >> b[4:0];
            F3Or: val = a | b;
            F3And: val = a & b;
            default: unk = 1'b1;
          endcase
        end else if (f7 == F7Alt) begin
          if (f3 == F3Add) val = a - b;
          else if (f3 == F3Srl) val = $signed(a) >>> b[4:0];
          else unk = 1'b1;
        end else if (f7 == F7MulDiv) begin
          if (f3 == F3Mul) val = a * b;
          else if (f3 == F3Div) val = signed_div(a, b, 1'b0);
          else if (f3 == F3Rem) val = signed_div(a, b, 1'b1);
          else unk = 1'b1;
        end else begin
          unk = 1'b1;
        end
      end
      rvc_pkg::OpImm: begin
        wr = 1'b1;
        case (f3)
          F3Add: val = a + immi;
          F3Slt: val = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
          F3Xor: val = a ^ immi;
          F3Or: val = a | immi;
          F3And: val = a & immi;
          F3Sll: if (f7 == F7Base) val = a << immi[4:0]; else unk = 1'b1;
          F3Srl: begin
            if (f7 == F7Base) val = a >> immi[4:0];
            else if (f7 == F7Alt) val = $signed(a) >>> immi[4:0];
            else unk = 1'b1;
          end
          default: unk = 1'b1;
        endcase
      end
      rvc_pkg::OpLoad: begin
        wr = 1'b1;
        addr = a + immi;
        m0 = mem_byte_at(addr);
        m1 = mem_byte_at(addr + 32'd1);
        m2 = mem_byte_at(addr + 32'd2);
        m3 = mem_byte_at(addr + 32'd3);
        case (f3)
          F3Byte: val = {{24{m0[7]}}, m0};
          F3Half: val = {{16{m1[7]}}, m1, m0};
          F3Word: val = {m3, m2, m1, m0};
          default: unk = 1'b1;
        endcase
      end
      rvc_pkg::OpStore: begin
        imm = {{20{w[31]}}, w[31:25], w[11:7]};
        addr = a + imm;
        if (f3 == F3Byte || f3 == F3Half || f3 == F3Word) begin
          for (int i = 0; i < (1 << f3); i++) begin
            shadow_mem[rvc_pkg::MemAw'(addr + 32'(i))] = b[8*i +: 8];
          end
        end else begin
          unk = 1'b1;
        end
      end
      rvc_pkg::OpBranch: begin
        imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3Beq: take = (a == b);
          F3Bne: take = (a != b);
          F3Blt: take = ($signed(a) < $signed(b));
          F3Bge: take = !($signed(a) < $signed(b));
          default: unk = 1'b1;
        endcase
        if (take) nxt = pc + imm;
      end
      rvc_pkg::OpJal: begin
        imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        wr = 1'b1;
        val = pc + 32'd4;
        nxt = pc + imm;
      end
      rvc_pkg::OpJalr: begin
        if (f3 == F3Add) begin
          wr = 1'b1;
          val = pc + 32'd4;
          nxt = (a + immi) & ~32'd1;
        end else begin
          unk = 1'b1;
        end
      end
      rvc_pkg::OpLui: begin
        wr = 1'b1;
        val = w & rvc_pkg::UpperMask;
      end
      rvc_pkg::OpAuipc: begin
        wr = 1'b1;
        val = pc + (w & rvc_pkg::UpperMask);
      end
      default: unk = 1'b1;
    endcase
    if (unk) begin
      wr = 1'b0;
      nxt = pc + 32'd4;
    end
    if (rd == 5'd0) wr = 1'b0;
    if (wr) shadow_regs[rd] = val;
    shadow_pc = nxt;
    r.executed_pc = pc;
    r.next_pc = nxt;
    r.reg_written = wr;
    r.dest_index = wr ? rd : 5'd0;
    r.dest_value = wr ? val : 32'd0;
    r.unknown_op = unk;
    return r;
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  // Build a random instruction, mostly well formed
  function automatic logic [31:0] random_instr();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [11:0] imm12;
    logic [12:0] boff;
    logic [20:0] joff;
    int k;
    k = $urandom_range(0, 99);
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3 = 3'($urandom_range(0, 7));
    imm12 = 12'($urandom());
    if (k < 8) return $urandom();
    if (k < 30) begin
      case ($urandom_range(0, 3))
        0: f7 = F7Alt;
        1: f7 = F7MulDiv;
        default: f7 = F7Base;
      endcase
      if ($urandom_range(0, 29) == 0) f7 = 7'($urandom());
      return {f7, rs2, rs1, f3, rd, rvc_pkg::OpReg};
    end
    if (k < 48) begin
      if (f3 == F3Sll || f3 == F3Srl) begin
        imm12[11:5] = ($urandom_range(0, 1) == 1) ? F7Alt : F7Base;
        if ($urandom_range(0, 19) == 0) imm12[11:5] = 7'($urandom());
      end
      return {imm12, rs1, f3, rd, rvc_pkg::OpImm};
    end
    if (k < 58) begin
      return {20'($urandom()), rd,
              ($urandom_range(0, 1) == 1) ? rvc_pkg::OpLui : rvc_pkg::OpAuipc};
    end
    // Loads and stores: keep half of the addresses in a small window so they overlap
    if ($urandom_range(0, 1) == 1) begin
      rs1 = 5'd0;
      imm12 = 12'($urandom_range(0, 40));
      if ($urandom_range(0, 9) == 0) imm12 = 12'hFFF - 12'($urandom_range(0, 3));
    end
    f3 = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(0, 2));
    if (k < 72) return {imm12, rs1, f3, rd, rvc_pkg::OpLoad};
    if (k < 86) return {imm12[11:5], rs2, rs1, f3, imm12[4:0], rvc_pkg::OpStore};
    if (k < 94) begin
      boff = 13'($urandom());
      case ($urandom_range(0, 4))
        0: f3 = F3Beq;
        1: f3 = F3Bne;
        2: f3 = F3Blt;
        3: f3 = F3Bge;
        default: f3 = 3'($urandom());
      endcase
      return {boff[12], boff[10:5], rs2, rs1, f3, boff[4:1], boff[11], rvc_pkg::OpBranch};
    end
    if (k < 97) begin
      joff = 21'($urandom());
      return {joff[20], joff[10:1], joff[11], joff[19:12], rd, rvc_pkg::OpJal};
    end
    f3 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : F3Add;
    return {imm12, rs1, f3, rd, rvc_pkg::OpJalr};
  endfunction

  task automatic add_row(logic [31:0] w, bit typed, logic [31:0] pc, logic [31:0] nxt,
                         logic wr, logic [4:0] rd, logic [31:0] val, logic unk);
    stim_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = '{pc, nxt, wr, rd, val, unk};
    directed_rows.push_back(row);
  endtask

  // Offer one request and record its expectation on acceptance
  task automatic send_request(stim_row_t row);
    rvc_pkg::core_result_t predicted;
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.instr_word <= row.word;
    do @(posedge clk); while (!in_ch.ready);
    predicted = execute_instr(row.word);
    pending_results.push_back(row.typed ? row.want : predicted);
  endtask

  // Stimulus
  initial begin
    stim_row_t row;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    for (int i = 0; i < rvc_pkg::MemBytes; i++) shadow_mem[i] = '0;
    shadow_regs[2] = 32'h7FFFFFDC;
    shadow_regs[3] = 32'h10000000;
    shadow_regs[10] = 32'd1;
    shadow_regs[11] = 32'h7FFFFFDC;
    shadow_pc = '0;

    // Directed table: reset values, division corners, x0 write, unknown encodings, other ops
    add_row(32'h800000B7, 1, 32'h00, 32'h04, 1, 5'd1, 32'h80000000, 0); // lui x1
    add_row(32'hFFF00213, 1, 32'h04, 32'h08, 1, 5'd4, 32'hFFFFFFFF, 0); // addi x4,x0,-1
    add_row(32'h0240C2B3, 1, 32'h08, 32'h0C, 1, 5'd5, 32'h80000000, 0); // div overflow
    add_row(32'h0240E333, 1, 32'h0C, 32'h10, 1, 5'd6, 32'h00000000, 0); // rem overflow
    add_row(32'h020543B3, 1, 32'h10, 32'h14, 1, 5'd7, 32'hFFFFFFFF, 0); // div by zero
    add_row(32'h02056433, 1, 32'h14, 32'h18, 1, 5'd8, 32'h00000001, 0); // rem by zero
    add_row(32'h00550013, 1, 32'h18, 32'h1C, 0, 5'd0, 32'h00000000, 0); // write to x0
    add_row(32'h00000000, 1, 32'h1C, 32'h20, 0, 5'd0, 32'h00000000, 1); // all zeros
    add_row(32'hFFFFFFFF, 1, 32'h20, 32'h24, 0, 5'd0, 32'h00000000, 1); // all ones
    add_row(32'h00B533B3, 0, 0, 0, 0, 0, 0, 0); // sltu is unknown
    add_row(32'hFE102FA3, 0, 0, 0, 0, 0, 0, 0); // sw wrapping past the end
    add_row(32'hFFF02483, 0, 0, 0, 0, 0, 0, 0); // lw wrapping
    add_row(32'hFFE01603, 0, 0, 0, 0, 0, 0, 0); // lh
    add_row(32'hFFF00683, 0, 0, 0, 0, 0, 0, 0); // lb
    add_row(32'h021586B3, 0, 0, 0, 0, 0, 0, 0); // mul
    add_row(32'h41F0D713, 0, 0, 0, 0, 0, 0, 0); // srai by 31
    add_row(32'hFFFFF797, 0, 0, 0, 0, 0, 0, 0); // auipc
    add_row(32'h00000463, 0, 0, 0, 0, 0, 0, 0); // beq taken
    add_row(32'h00B51463, 0, 0, 0, 0, 0, 0, 0); // bne
    add_row(32'h0015C463, 0, 0, 0, 0, 0, 0, 0); // blt
    add_row(32'h00A5D463, 0, 0, 0, 0, 0, 0, 0); // bge
    add_row(32'hFF9FF0EF, 0, 0, 0, 0, 0, 0, 0); // jal backward
    add_row(32'h000500E7, 0, 0, 0, 0, 0, 0, 0); // jalr odd target
    add_row(32'h00051067, 0, 0, 0, 0, 0, 0, 0); // jalr bad funct3

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random programs
    row.typed = 0;
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 300 && n < 500);
      hold_sink = hold_sink || (n == 600);
      if (n == 800) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      row.word = random_instr();
      send_request(row);
    end
    in_ch.valid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("rv32im_subset_core_step: match");
    end else begin
      $display("rv32im_subset_core_step: mismatch");
    end
    $finish;
  end

  // Sink readiness, with one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    rvc_pkg::core_result_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: pc %h", got.executed_pc);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.executed_pc !== want.executed_pc) begin
          $error("executed_pc: expected %h, got %h", want.executed_pc, got.executed_pc);
          fail_count++;
        end
        if (got.next_pc !== want.next_pc) begin
          $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
          fail_count++;
        end
        if (got.reg_written !== want.reg_written) begin
          $error("reg_written: expected %b, got %b", want.reg_written, got.reg_written);
          fail_count++;
        end
        if (got.dest_index !== want.dest_index) begin
          $error("dest_index: expected %0d, got %0d", want.dest_index, got.dest_index);
          fail_count++;
        end
        if (got.dest_value !== want.dest_value) begin
          $error("dest_value: expected %h, got %h", want.dest_value, got.dest_value);
          fail_count++;
        end
        if (got.unknown_op !== want.unknown_op) begin
          $error("unknown_op: expected %b, got %b", want.unknown_op, got.unknown_op);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("rv32im_subset_core_step: mismatch");
      $finish;
    end
  end
endmodule

// ===== rv32im_subset_core_step.f =====
+incdir+src
src/rvc_pkg.sv
src/rvc_stream_if.sv
src/rvc_ctrl.sv
src/rvc_datapath.sv
src/rv32im_subset_core_step.sv
src/rvc_checker.sv
tb/rv32im_subset_core_step_tb.sv
